// ===== hdl/udpfb_pkg.sv =====
// ----------------------------------------------------------------------------
// udpfb_pkg
// Shared types and constants for the UDP/IPv4/Ethernet transmit framer.
// ----------------------------------------------------------------------------
`default_nettype none

package udpfb_pkg;

  localparam int MAX_FRAME_DEF = 1518;
  localparam int HDR_LEN       = 42;
  localparam int QUEUE_DEPTH   = 4;

  localparam logic [5:0] HDR_LAST_IDX = 6'(HDR_LEN - 1);

  // Input command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  // Register indexes (8-byte stride on the config port)
  localparam logic [2:0] REG_DEST_MAC    = 3'd0;
  localparam logic [2:0] REG_SOURCE_MAC  = 3'd1;
  localparam logic [2:0] REG_DEST_IP     = 3'd2;
  localparam logic [2:0] REG_SOURCE_IP   = 3'd3;
  localparam logic [2:0] REG_SOURCE_PORT = 3'd4;
  localparam logic [2:0] REG_DEST_PORT   = 3'd5;

  // Fixed header fields
  localparam logic [7:0]  ETH_TYPE_HI = 8'h08;
  localparam logic [7:0]  IP_VER_IHL  = 8'h45;
  localparam logic [7:0]  IP_TTL      = 8'd128;
  localparam logic [7:0]  IP_PROTO    = 8'd17;
  localparam logic [15:0] IP_LEN_BASE  = 16'd28;
  localparam logic [15:0] UDP_LEN_BASE = 16'd8;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_HDR  = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  // One queued job: a body byte, a header burst or an error word
  typedef struct packed {
    kind_t        kind;
    logic [10:0]  len;
    logic [7:0]   data;
    logic         last;
    logic [15:0]  ident;
  } job_t;

  typedef struct packed {
    logic [47:0] dest_mac;
    logic [47:0] source_mac;
    logic [31:0] dest_ip;
    logic [31:0] source_ip;
    logic [15:0] source_port;
    logic [15:0] dest_port;
  } cfg_t;

endpackage

`default_nettype wire

// ===== hdl/udpfb_front.sv =====
// ----------------------------------------------------------------------------
// udpfb_front
// Accepts input words, tracks frame state and queues jobs for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module udpfb_front
  import udpfb_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        command,
  input  wire logic [10:0] body_length,
  input  wire logic [7:0]  data_byte,
  input  wire logic        q_full,
  output logic             q_push,
  output job_t             q_job
);

  localparam int BODY_LIMIT = MAX_FRAME - HDR_LEN;

  // a frame is open exactly while body bytes remain
  logic [15:0] packet_ident, packet_ident_next;
  logic [10:0] bytes_remaining, bytes_remaining_next;
  logic        too_long;

  assign in_ready = !q_full;
  assign too_long = (32'(body_length) > 32'(BODY_LIMIT));

  always_comb begin
    q_push               = 1'b0;
    q_job.kind           = KIND_DATA;
    q_job.len            = body_length;
    q_job.data           = data_byte;
    q_job.last           = (bytes_remaining == 11'd1);
    q_job.ident          = packet_ident;
    packet_ident_next    = packet_ident;
    bytes_remaining_next = bytes_remaining;
    if (in_valid && in_ready) begin
      if (command == CMD_DATA) begin
        if (bytes_remaining != 11'd0) begin
          q_push               = 1'b1;
          bytes_remaining_next = bytes_remaining - 11'd1;
        end
      end else if (too_long) begin
        q_push               = 1'b1;
        q_job.kind           = KIND_ERR;
        bytes_remaining_next = 11'd0;
      end else begin
        q_push               = 1'b1;
        q_job.kind           = KIND_HDR;
        packet_ident_next    = packet_ident + 16'd1;
        bytes_remaining_next = body_length;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_ident    <= 16'd0;
      bytes_remaining <= 11'd0;
    end else begin
      packet_ident    <= packet_ident_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/udpfb_queue.sv =====
// ----------------------------------------------------------------------------
// udpfb_queue
// Short register FIFO of jobs between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module udpfb_queue
  import udpfb_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  job_t      push_job,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output job_t      head_job
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  job_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full       = (count == CW'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/udpfb_back.sv =====
// ----------------------------------------------------------------------------
// udpfb_back
// Turns queued jobs into output words: header bursts, body bytes, errors.
// ----------------------------------------------------------------------------
`default_nettype none

module udpfb_back
  import udpfb_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  cfg_t            cfg,
  input  wire logic       head_valid,
  input  job_t            head_job,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      frame_byte,
  output logic            last,
  output logic            error
);

  logic [5:0]  hdr_idx;
  logic [18:0] csum;      // running ones'-complement sum, folded at idx 8 and 9
  logic [15:0] ck;
  logic [15:0] ip_len, udp_len;
  logic [15:0] sum_word;
  logic [7:0]  hdr_byte;
  logic        load;
  logic        hdr_done;

  assign ip_len   = IP_LEN_BASE + 16'(head_job.len);
  assign udp_len  = UDP_LEN_BASE + 16'(head_job.len);
  assign ck       = ~csum[15:0];
  assign load     = head_valid && (!out_valid || out_ready);
  assign hdr_done = (hdr_idx == HDR_LAST_IDX);

  // checksum word fed in at each of the first eight header bytes
  always_comb begin
    unique case (hdr_idx[2:0])
      3'd0:    sum_word = {IP_VER_IHL, 8'h00};
      3'd1:    sum_word = ip_len;
      3'd2:    sum_word = head_job.ident;
      3'd3:    sum_word = {IP_TTL, IP_PROTO};
      3'd4:    sum_word = cfg.source_ip[31:16];
      3'd5:    sum_word = cfg.source_ip[15:0];
      3'd6:    sum_word = cfg.dest_ip[31:16];
      3'd7:    sum_word = cfg.dest_ip[15:0];
      default: sum_word = 16'h0000;
    endcase
  end

  always_comb begin
    unique case (hdr_idx)
      6'd0:    hdr_byte = cfg.dest_mac[47:40];
      6'd1:    hdr_byte = cfg.dest_mac[39:32];
      6'd2:    hdr_byte = cfg.dest_mac[31:24];
      6'd3:    hdr_byte = cfg.dest_mac[23:16];
      6'd4:    hdr_byte = cfg.dest_mac[15:8];
      6'd5:    hdr_byte = cfg.dest_mac[7:0];
      6'd6:    hdr_byte = cfg.source_mac[47:40];
      6'd7:    hdr_byte = cfg.source_mac[39:32];
      6'd8:    hdr_byte = cfg.source_mac[31:24];
      6'd9:    hdr_byte = cfg.source_mac[23:16];
      6'd10:   hdr_byte = cfg.source_mac[15:8];
      6'd11:   hdr_byte = cfg.source_mac[7:0];
      6'd12:   hdr_byte = ETH_TYPE_HI;
      6'd14:   hdr_byte = IP_VER_IHL;
      6'd16:   hdr_byte = ip_len[15:8];
      6'd17:   hdr_byte = ip_len[7:0];
      6'd18:   hdr_byte = head_job.ident[15:8];
      6'd19:   hdr_byte = head_job.ident[7:0];
      6'd22:   hdr_byte = IP_TTL;
      6'd23:   hdr_byte = IP_PROTO;
      6'd24:   hdr_byte = ck[15:8];
      6'd25:   hdr_byte = ck[7:0];
      6'd26:   hdr_byte = cfg.source_ip[31:24];
      6'd27:   hdr_byte = cfg.source_ip[23:16];
      6'd28:   hdr_byte = cfg.source_ip[15:8];
      6'd29:   hdr_byte = cfg.source_ip[7:0];
      6'd30:   hdr_byte = cfg.dest_ip[31:24];
      6'd31:   hdr_byte = cfg.dest_ip[23:16];
      6'd32:   hdr_byte = cfg.dest_ip[15:8];
      6'd33:   hdr_byte = cfg.dest_ip[7:0];
      6'd34:   hdr_byte = cfg.source_port[15:8];
      6'd35:   hdr_byte = cfg.source_port[7:0];
      6'd36:   hdr_byte = cfg.dest_port[15:8];
      6'd37:   hdr_byte = cfg.dest_port[7:0];
      6'd38:   hdr_byte = udp_len[15:8];
      6'd39:   hdr_byte = udp_len[7:0];
      default: hdr_byte = 8'h00;   // zero fields: type low, TOS, flags, UDP csum
    endcase
  end

  always_comb begin
    pop = 1'b0;
    if (load) begin
      unique case (head_job.kind)
        KIND_HDR: pop = hdr_done;
        default:  pop = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      unique case (head_job.kind)
        KIND_DATA: begin
          frame_byte <= head_job.data;
          last       <= head_job.last;
          error      <= 1'b0;
        end
        KIND_HDR: begin
          frame_byte <= hdr_byte;
          last       <= hdr_done && (head_job.len == 11'd0);
          error      <= 1'b0;
        end
        default: begin
          frame_byte <= 8'h00;
          last       <= 1'b0;
          error      <= 1'b1;
        end
      endcase
    end
    if (load && head_job.kind == KIND_HDR) begin
      if (hdr_idx == 6'd0) begin
        csum <= 19'(sum_word);
      end else if (hdr_idx < 6'd8) begin
        csum <= csum + 19'(sum_word);
      end else if (hdr_idx < 6'd10) begin
        csum <= 19'(csum[15:0]) + 19'(csum[18:16]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      hdr_idx   <= 6'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (load && head_job.kind == KIND_HDR) begin
        hdr_idx <= hdr_done ? 6'd0 : hdr_idx + 6'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/udp_ipv4_ethernet_frame_builder.sv =====
// ----------------------------------------------------------------------------
// udp_ipv4_ethernet_frame_builder
// Transmit framer: builds Ethernet/IPv4/UDP headers and streams the body.
// ----------------------------------------------------------------------------
//
//  channel   signals                                  dir  notes
//  -------   ---------------------------------------  ---  --------------------
//  in        in_valid/in_ready, command, body_length,  in   start or body byte
//            data_byte
//  out       out_valid/out_ready, frame_byte, last,    out  one frame byte/word
//            error
//  config    psel/penable/pwrite/paddr/pwdata/prdata   in   64-bit regs, 8-byte
//            /pready                                         stride
//
//  Body bytes pass at one word per cycle while the output is not stalled; an
//  accepted word is written into a queue slot, then into the output register.
//  A start word produces a 42-byte header burst from the back end; an
//  oversized length gives one error word.
//  Synchronous active-high reset clears frame state, identification and
//  config registers.
//  A four-entry job queue lets the front keep accepting while the output
//  stalls; in_ready drops only when the queue is full.
// ----------------------------------------------------------------------------
`default_nettype none

module udp_ipv4_ethernet_frame_builder
  import udpfb_pkg::*;
#(
  parameter int MAX_FRAME = MAX_FRAME_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        command,
  input  wire logic [10:0] body_length,
  input  wire logic [7:0]  data_byte,
  // output channel
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       frame_byte,
  output logic             last,
  output logic             error,
  // config port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [5:0]  paddr,
  input  wire logic [63:0] pwdata,
  output logic [63:0]      prdata,
  output logic             pready
);

  cfg_t       cfg;
  logic [2:0] reg_idx;
  logic       cfg_wr;

  logic q_full, q_push, q_pop, q_head_valid;
  job_t q_job, q_head;

  // --------------------------------------------------------------------------
  // Config registers; the user, not the block, ensures they are only written while the datapath is idle
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_DEST_MAC:    cfg.dest_mac    <= pwdata[47:0];
        REG_SOURCE_MAC:  cfg.source_mac  <= pwdata[47:0];
        REG_DEST_IP:     cfg.dest_ip     <= pwdata[31:0];
        REG_SOURCE_IP:   cfg.source_ip   <= pwdata[31:0];
        REG_SOURCE_PORT: cfg.source_port <= pwdata[15:0];
        REG_DEST_PORT:   cfg.dest_port   <= pwdata[15:0];
        default: ;       // unmapped: write ignored
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_DEST_MAC:    prdata = {16'h0000, cfg.dest_mac};
      REG_SOURCE_MAC:  prdata = {16'h0000, cfg.source_mac};
      REG_DEST_IP:     prdata = {32'h0, cfg.dest_ip};
      REG_SOURCE_IP:   prdata = {32'h0, cfg.source_ip};
      REG_SOURCE_PORT: prdata = {48'h0, cfg.source_port};
      REG_DEST_PORT:   prdata = {48'h0, cfg.dest_port};
      default:         prdata = 64'h0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Front end: classify words, keep ident and remaining byte count
  // --------------------------------------------------------------------------
  udpfb_front #(
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .body_length (body_length),
    .data_byte   (data_byte),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_job       (q_job)
  );

  // --------------------------------------------------------------------------
  // Job queue
  // --------------------------------------------------------------------------
  udpfb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head)
  );

  // --------------------------------------------------------------------------
  // Back end: header sequencer, checksum and output register
  // --------------------------------------------------------------------------
  udpfb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (q_head_valid),
    .head_job   (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_byte (frame_byte),
    .last       (last),
    .error      (error)
  );

endmodule

`default_nettype wire
